### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the translator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define PTW_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the page table walk translator.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [2:0] ST_KERNEL  = 3'd0;
  localparam logic [2:0] ST_DIRECT  = 3'd1;
  localparam logic [2:0] ST_PAGE_4K = 3'd2;
  localparam logic [2:0] ST_PAGE_2M = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;

  localparam logic [2:0] CFG_KERNEL_VIRT_BASE  = 3'd0;
  localparam logic [2:0] CFG_KERNEL_PHYS_BASE  = 3'd1;
  localparam logic [2:0] CFG_KERNEL_WINDOW_LEN = 3'd2;
  localparam logic [2:0] CFG_DIRECT_MAP_BASE   = 3'd3;
  localparam logic [2:0] CFG_ROOT_TABLE_ADDR   = 3'd4;

  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd0;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef struct packed {
    logic        op;
    logic [63:0] virt_addr;
    logic [11:0] word_index;
    logic [63:0] word_data;
  } in_item_t;

  typedef struct packed {
    logic [51:0] phys_addr;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [63:0] kernel_virt_base;
    logic [51:0] kernel_phys_base;
    logic [48:0] kernel_window_len;
    logic [63:0] direct_map_base;
    logic [51:0] root_table_addr;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_DONE,
    CMD_WALK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [51:0] phys_addr;
    logic [2:0]  status;
    logic [47:0] virt_addr;
    logic [11:0] word_index;
    logic [63:0] word_data;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

### rtl/ptw_ram.sv
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accepts items, checks the kernel and direct-map windows and queues commands.
// ----------------------------------------------------------------------------
module ptw_front #(
  parameter logic [63:0] DIRECT_WINDOW_BYTES = 64'd4294967296
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptw_pkg::in_item_t  in_item,
  input  ptw_pkg::cfg_regs_t cfg,
  input  logic               q_full,
  output logic               q_push,
  output ptw_pkg::cmd_t      q_cmd
);
  import ptw_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  in_item_t    a_item_r;
  logic [64:0] a_dk_r, a_dd_r;
  logic        accept, k_hit, d_hit;

  assign q_push   = a_valid_r && !q_full;
  assign in_stall = a_valid_r && !q_push;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // Each subtraction keeps its borrow in the top bit, set when the address is below the base.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_item_r <= in_item;
      a_dk_r   <= {1'b0, in_item.virt_addr} - {1'b0, cfg.kernel_virt_base};
      a_dd_r   <= {1'b0, in_item.virt_addr} - {1'b0, cfg.direct_map_base};
    end
  end

  assign k_hit = !a_dk_r[64] && (a_dk_r[63:0] < {15'd0, cfg.kernel_window_len});
  assign d_hit = !a_dd_r[64] && (a_dd_r[63:0] < DIRECT_WINDOW_BYTES);

  always_comb begin
    q_cmd            = '0;
    q_cmd.virt_addr  = a_item_r.virt_addr[47:0];
    q_cmd.word_index = a_item_r.word_index;
    q_cmd.word_data  = a_item_r.word_data;
    if (a_item_r.op == OP_WRITE) begin
      q_cmd.kind = CMD_WRITE;
    end else if (k_hit) begin
      q_cmd.kind      = CMD_DONE;
      q_cmd.phys_addr = a_dk_r[51:0] + cfg.kernel_phys_base;
      q_cmd.status    = ST_KERNEL;
    end else if (d_hit) begin
      q_cmd.kind      = CMD_DONE;
      q_cmd.phys_addr = a_dd_r[51:0];
      q_cmd.status    = ST_DIRECT;
    end else begin
      q_cmd.kind = CMD_WALK;
    end
  end

endmodule

### rtl/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Two-entry command queue between the classifying front and the walking back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ptw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output ptw_pkg::cmd_t head
);
  import ptw_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `PTW_NEVER(a_push_full, push && full, "Command pushed into a full queue.")
  `PTW_NEVER(a_pop_empty, pop && !valid, "Command popped from an empty queue.")
  `PTW_ASSERT(a_cnt_bound, cnt_r != 2'd3, "Queue count out of range.")

endmodule

### rtl/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Executes queued commands: table writes, window results and four-level walks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptw_back #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [51:0]         root_table_addr,
  input  logic                q_valid,
  input  ptw_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ptw_pkg::out_item_t  out_item
);
  import ptw_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);

  back_state_t     state_r, state_nxt;
  logic [1:0]      lvl_r, lvl_nxt;
  logic [47:0]     va_r, va_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic            out_free, load_res, walk_done;
  out_item_t       res;
  logic [63:0]     entry;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [39:0]     next_frame;
  logic [8:0]      next_idx;
  logic [48:0]     walk_word;
  logic [31:0]     widx_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign widx_ext  = 32'(q_cmd.word_index);
  assign ram_waddr = widx_ext[AW-1:0];
  assign walk_word = {next_frame, next_idx};
  assign ram_raddr = walk_word[AW-1:0];

  ptw_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (q_cmd.word_data),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (entry)
  );

  assign walk_done = !entry[BIT_PRESENT] || (lvl_r == LVL_PD && entry[BIT_LARGE]) ||
                     (lvl_r == LVL_PT);

  always_comb begin
    res = '0;
    if (!entry[BIT_PRESENT]) begin
      res.status = ST_FAULT;
    end else if (lvl_r == LVL_PD) begin
      res.phys_addr = {entry[51:21], va_r[20:0]};
      res.status    = ST_PAGE_2M;
    end else begin
      res.phys_addr = {entry[51:12], va_r[11:0]};
      res.status    = ST_PAGE_4K;
    end
  end

  // Datapath and handshake outputs.
  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    load_res     = 1'b0;
    lvl_nxt      = lvl_r;
    va_nxt       = va_r;
    out_item_nxt = out_item_r;
    next_frame   = entry[51:12];
    next_idx     = va_r[38:30];
    case (state_r)
      BK_IDLE: begin
        next_frame = root_table_addr[51:12];
        next_idx   = q_cmd.virt_addr[47:39];
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_WRITE: begin
              ram_we = 1'b1;
              q_pop  = 1'b1;
            end
            CMD_DONE: begin
              if (out_free) begin
                load_res               = 1'b1;
                out_item_nxt.phys_addr = q_cmd.phys_addr;
                out_item_nxt.status    = q_cmd.status;
                q_pop                  = 1'b1;
              end
            end
            CMD_WALK: begin
              ram_re  = 1'b1;
              q_pop   = 1'b1;
              va_nxt  = q_cmd.virt_addr;
              lvl_nxt = LVL_PML4;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_WALK: begin
        case (lvl_r)
          LVL_PML4: next_idx = va_r[38:30];
          LVL_PDPT: next_idx = va_r[29:21];
          default:  next_idx = va_r[20:12];
        endcase
        if (walk_done) begin
          if (out_free) begin
            load_res     = 1'b1;
            out_item_nxt = res;
          end
        end else begin
          ram_re  = 1'b1;
          lvl_nxt = lvl_r - 2'd1;
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = load_res ? 1'b1 : (out_valid_r && out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_cmd.kind == CMD_WALK) begin
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        if (load_res) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    va_r       <= va_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PTW_NEVER(a_no_write_in_walk, ram_we && state_r == BK_WALK,
             "Table written while a walk is in progress.")

endmodule

### rtl/page_table_walk_translate_top.sv
// ----------------------------------------------------------------------------
// page_table_walk_translate_top
// A window hit passes the front stage register, a queue entry and the output
// register; a walk adds up to four dependent reads of the registered table RAM.
// One write or window hit per cycle unless a stall or a walk holds the flow; the
// back takes no new command during a walk. Reset clears all configuration
// registers, the queue and the walker; the table store is not cleared.
// ----------------------------------------------------------------------------
module page_table_walk_translate_top #(
  parameter int          TABLE_WORDS         = 4096,
  parameter logic [63:0] DIRECT_WINDOW_BYTES = 64'd4294967296
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ptw_pkg::out_item_t out_item
);
  import ptw_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_push, q_full, q_pop, q_valid;
  cmd_t      push_cmd, head_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KERNEL_VIRT_BASE:  cfg_nxt.kernel_virt_base  = cfg_data;
        CFG_KERNEL_PHYS_BASE:  cfg_nxt.kernel_phys_base  = cfg_data[51:0];
        CFG_KERNEL_WINDOW_LEN: cfg_nxt.kernel_window_len = cfg_data[48:0];
        CFG_DIRECT_MAP_BASE:   cfg_nxt.direct_map_base   = cfg_data;
        CFG_ROOT_TABLE_ADDR:   cfg_nxt.root_table_addr   = cfg_data[51:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ptw_front #(
    .DIRECT_WINDOW_BYTES (DIRECT_WINDOW_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ptw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  ptw_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .root_table_addr (cfg_r.root_table_addr),
    .q_valid         (q_valid),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item)
  );

endmodule
